### design/qpx_pkg.sv
// Shared types and constants for the query parameter extractor.
// Used by the front end, the bundle queue, the back end and the top level.
// No dependencies.
`default_nettype none

package qpx_pkg;

	localparam int KEY_BYTES_DEF    = 8;
	localparam int MAX_CAPACITY_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_KEY_TEXT  = 2'd0;
	localparam logic [1:0] REG_KEY_LEN   = 2'd1;
	localparam logic [1:0] REG_VALUE_CAP = 2'd2;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Result items caused by one query byte. Items are taken in order from
	// index 0; when stat is set, the last item is the status item.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n;
		logic            stat;
		logic            sfound;
	} qpx_entry_t;

endpackage

`default_nettype wire

### design/qpx_front.sv
// Front end: holds the configuration registers and the parser state, and
// turns each query byte into a bundle of up to three result items.
// Depends on qpx_pkg.
`default_nettype none

module qpx_front
	import qpx_pkg::*;
#(
	parameter int KEY_BYTES    = KEY_BYTES_DEF,
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic [7:0]  in_byte,
	input  wire logic        q_full,
	output logic             push,
	output qpx_entry_t       push_entry
);

	localparam int CW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
	localparam int LW = (CW + 1 > 13) ? CW + 1 : 13;

	typedef enum logic [5:0] {
		PH_MATCH = 6'b000001,
		PH_SKIP  = 6'b000010,
		PH_VALUE = 6'b000100,
		PH_PCT   = 6'b001000,
		PH_PCT1  = 6'b010000,
		PH_DONE  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       done;
		logic       pct;
		logic [7:0] data;
	} vb_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) v = c - 8'h30;
		else if (c >= 8'h61) v = c - 8'h57;
		else v = c - 8'h37;
		return v[3:0];
	endfunction

	// Ordinary value byte: '&' or a full buffer ends the value.
	function automatic vb_t value_byte(input logic [7:0] c, input logic full);
		vb_t r;
		r.done = (c == CH_AMP) || full;
		r.pct  = (c == CH_PERCENT);
		r.data = (c == CH_PLUS) ? CH_SPACE : c;
		return r;
	endfunction

	logic [63:0] key_text_q;
	logic [3:0]  key_len_q;
	logic [12:0] value_cap_q;

	phase_t      phase_q;
	logic [3:0]  kpos_q;
	logic [7:0]  held_q;
	logic [CW-1:0] cnt_q;
	logic        found_q;

	logic [LW-1:0] cap_w;
	logic [CW-1:0] limit;
	logic [3:0]    klen;
	logic          accept;

	phase_t        ph;
	logic [3:0]    kp;
	logic [7:0]    held;
	logic [CW-1:0] cnt;
	logic          fnd;
	logic          pending;
	vb_t           vb;
	qpx_entry_t    ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q  <= '0;
			key_len_q   <= '0;
			value_cap_q <= 13'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_TEXT:  key_text_q  <= cfg_data;
				REG_KEY_LEN:   key_len_q   <= cfg_data[3:0];
				REG_VALUE_CAP: value_cap_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cap_w = LW'(value_cap_q);
		if (cap_w == '0) cap_w = LW'(1);
		if (cap_w > LW'(MAX_CAPACITY)) cap_w = LW'(MAX_CAPACITY);
		limit = CW'(cap_w - LW'(1));
		klen  = (key_len_q > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len_q;
	end

	always_comb begin
		ph      = phase_q;
		kp      = kpos_q;
		held    = held_q;
		cnt     = cnt_q;
		fnd     = found_q;
		pending = 1'b1;
		vb      = '0;
		ent     = '0;

		if (phase_q == PH_PCT) begin
			if (in_byte != 8'h00 && is_hex(in_byte)) begin
				held    = in_byte;
				ph      = PH_PCT1;
				pending = 1'b0;
			end else begin
				if (cnt < limit) begin
					ent.bytes[ent.n] = CH_PERCENT;
					ent.n = ent.n + 2'd1;
					cnt   = cnt + CW'(1);
				end
				ph = PH_VALUE;
			end
		end else if (phase_q == PH_PCT1) begin
			if (in_byte != 8'h00 && is_hex(in_byte) && is_hex(held_q)) begin
				if (cnt < limit) begin
					ent.bytes[ent.n] = {hex_val(held_q), hex_val(in_byte)};
					ent.n = ent.n + 2'd1;
					cnt   = cnt + CW'(1);
				end
				ph      = PH_VALUE;
				pending = 1'b0;
			end else begin
				// Lone percent: emit it, then replay the held digit as a value byte.
				if (cnt < limit) begin
					ent.bytes[ent.n] = CH_PERCENT;
					ent.n = ent.n + 2'd1;
					cnt   = cnt + CW'(1);
				end
				ph = PH_VALUE;
				vb = value_byte(held_q, cnt >= limit);
				if (vb.done) ph = PH_DONE;
				else if (vb.pct) ph = PH_PCT;
				else if (cnt < limit) begin
					ent.bytes[ent.n] = vb.data;
					ent.n = ent.n + 2'd1;
					cnt   = cnt + CW'(1);
				end
			end
			held = 8'h00;
		end

		if (pending) begin
			if (in_byte == 8'h00) begin
				ent.stat   = 1'b1;
				ent.sfound = fnd;
				ent.n      = ent.n + 2'd1;
				ph   = PH_MATCH;
				kp   = '0;
				held = '0;
				cnt  = '0;
				fnd  = 1'b0;
			end else if (ph == PH_MATCH) begin
				if (in_byte == CH_AMP) begin
					kp = '0;
				end else if (kp < klen) begin
					if (in_byte == key_text_q[{kp[2:0], 3'b000} +: 8]) kp = kp + 4'd1;
					else ph = PH_SKIP;
				end else if (in_byte == CH_EQUAL) begin
					fnd = 1'b1;
					cnt = '0;
					ph  = PH_VALUE;
				end else begin
					ph = PH_SKIP;
				end
			end else if (ph == PH_SKIP) begin
				if (in_byte == CH_AMP) begin
					kp = '0;
					ph = PH_MATCH;
				end
			end else if (ph == PH_VALUE) begin
				vb = value_byte(in_byte, cnt >= limit);
				if (vb.done) ph = PH_DONE;
				else if (vb.pct) ph = PH_PCT;
				else if (cnt < limit) begin
					ent.bytes[ent.n] = vb.data;
					ent.n = ent.n + 2'd1;
					cnt   = cnt + CW'(1);
				end
			end
		end
	end

	assign accept     = in_valid && !q_full;
	assign push       = accept && (ent.n != 2'd0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MATCH;
			kpos_q  <= '0;
			held_q  <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (accept) begin
			phase_q <= ph;
			kpos_q  <= kp;
			held_q  <= held;
			cnt_q   <= cnt;
			found_q <= fnd;
		end
	end

	property p_held_digit_in_pct1;
		@(posedge clk) disable iff (!arst_n) (phase_q == PH_PCT1) |-> is_hex(held_q);
	endproperty
	a_held_digit_in_pct1: assert property (p_held_digit_in_pct1)
		else $error("second percent digit expected without a held hex digit");

	property p_count_in_limit;
		@(posedge clk) disable iff (!arst_n) (cnt_q != '0) |-> (cnt_q <= limit);
	endproperty
	a_count_in_limit: assert property (p_count_in_limit)
		else $error("emitted count beyond the value limit");

	property p_end_clears;
		@(posedge clk) disable iff (!arst_n)
			(accept && in_byte == 8'h00) |=> (phase_q == PH_MATCH && !found_q && cnt_q == '0);
	endproperty
	a_end_clears: assert property (p_end_clears)
		else $error("state not cleared after end of query");

endmodule

`default_nettype wire

### design/qpx_queue.sv
// Short bundle queue between the front end and the back end.
// Flip-flop storage, one write and one head read per cycle. Depends on qpx_pkg.
`default_nettype none

module qpx_queue
	import qpx_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire qpx_entry_t  push_entry,
	input  wire logic        pop,
	output logic             full,
	output logic             empty,
	output qpx_entry_t       head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	qpx_entry_t      store_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CNTW-1:0] count_q;

	assign full  = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) count_q <= count_q + CNTW'(1);
			else if (pop && !push) count_q <= count_q - CNTW'(1);
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) full |-> !push;
	endproperty
	a_no_overflow: assert property (p_no_overflow)
		else $error("push into a full queue");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) empty |-> !pop;
	endproperty
	a_no_underflow: assert property (p_no_underflow)
		else $error("pop from an empty queue");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNTW'(DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

### design/qpx_back.sv
// Back end: walks the items of the head bundle and presents one per cycle
// on the output stream while m_tready is high. Depends on qpx_pkg.
`default_nettype none

module qpx_back
	import qpx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire qpx_entry_t  head,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic [1:0]       m_tuser
);

	logic [1:0] idx_q;
	logic       last_item;
	logic       is_stat;

	assign m_tvalid  = !q_empty;
	assign last_item = (idx_q == head.n - 2'd1);
	assign is_stat   = head.stat && last_item;
	assign m_tdata   = is_stat ? 8'h00 : head.bytes[idx_q];
	assign m_tlast   = last_item;
	assign m_tuser   = {is_stat ? head.sfound : 1'b1, is_stat};
	assign pop       = m_tvalid && m_tready && last_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= last_item ? 2'd0 : idx_q + 2'd1;
		end
	end

	property p_bundle_nonempty;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> (head.n != 2'd0);
	endproperty
	a_bundle_nonempty: assert property (p_bundle_nonempty)
		else $error("empty bundle at the queue head");

	property p_index_in_bundle;
		@(posedge clk) disable iff (!arst_n) m_tvalid |-> (idx_q < head.n);
	endproperty
	a_index_in_bundle: assert property (p_index_in_bundle)
		else $error("item index beyond the bundle");

	property p_status_is_last;
		@(posedge clk) disable iff (!arst_n) (m_tvalid && m_tuser[0]) |-> m_tlast;
	endproperty
	a_status_is_last: assert property (p_status_is_last)
		else $error("status item not marked last");

endmodule

`default_nettype wire

### design/query_param_extract_url_decode.sv
// Query string parameter extractor with percent decoding.
// The slave stream takes one query byte per transaction; a zero byte ends
// the query. For the first pair whose name equals the configured key, the
// decoded value bytes leave on the master stream, followed at the end of the
// query by a status transaction (tuser[0] set) that carries the found flag.
// tlast marks the final result of each input byte.
// Throughput: one input byte per cycle while the output keeps up; a byte that
// yields k results (at most three, after a lone percent) occupies the output
// for k transactions. The four-entry bundle queue between front end and
// back end absorbs such bursts and output stalls; s_tready falls only when
// it is full. Each result is registered in the bundle queue on its way out.
// Reset clears the parser state and the queue and loads the register reset
// values (empty key, capacity 64). Configuration writes take effect at once
// and are meant for idle periods. There is no clearing pass.
// Depends on qpx_pkg, qpx_front, qpx_queue and qpx_back.
`default_nettype none

module query_param_extract_url_decode
	import qpx_pkg::*;
#(
	parameter int KEY_BYTES    = KEY_BYTES_DEF,
	parameter int MAX_CAPACITY = MAX_CAPACITY_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] query_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast,
	output logic [1:0]       m_tuser    // [0] is_status, [1] found
);

	logic       q_full;
	logic       q_empty;
	logic       push;
	logic       pop;
	qpx_entry_t push_entry;
	qpx_entry_t head;

	assign s_tready = !q_full;

	qpx_front #(
		.KEY_BYTES   (KEY_BYTES),
		.MAX_CAPACITY(MAX_CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	qpx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	qpx_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

`default_nettype wire
